// File: src/set_assoc_cache_controller_assert.svh
// Assertion macros for the cache controller checker
`ifndef SET_ASSOC_CACHE_CONTROLLER_ASSERT_SVH
`define SET_ASSOC_CACHE_CONTROLLER_ASSERT_SVH
`define SACC_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbl failed");
`define SACC_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbl failed");
`endif

// File: src/sacc_pkg.sv
// ----------------------------------------------------------------------------
// Cache controller package
// Register indexes and policy codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sacc_pkg;
  localparam logic [1:0] POL_LRU = 2'd0;
  localparam logic [1:0] POL_LFU = 2'd1;
  localparam logic [1:0] POL_FIFO = 2'd2;
  localparam logic [1:0] POL_WAY0 = 2'd3;
  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_WB_MODE = 2'd1;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
endpackage

// File: src/sacc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/set_assoc_cache_controller.sv
// ----------------------------------------------------------------------------
// Set-associative cache controller
// Tag lookup, victim choice and policy counter update per access.
// Start is registered into a busy phase, and the done strobe is registered from that phase.
// A new start is taken only when not busy; the set read and its write-back use the set RAM.
// Reset clears valid, dirty, counters, FIFO pointers and stamp at once by
// way of per-set valid marks; no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module set_assoc_cache_controller import sacc_pkg::*; #(
  parameter int SETS = 16,
  parameter int WAYS = 4,
  parameter int BLOCK_WORDS = 4,
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [15:0] word_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  output logic        done,
  output logic        hit,
  output logic [1:0]  way_used,
  output logic [3:0]  set_number,
  output logic [1:0]  word_offset,
  output logic        fill_request,
  output logic        writeback_request,
  output logic [13:0] victim_block,
  output logic        store_through
);
  localparam int OB = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 0;
  localparam int SB = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SBR = (SETS > 1) ? $clog2(SETS) : 0;
  localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TB = ADDR_BITS - OB - SBR;
  localparam int LW = 1 + 1 + TB + 32;
  localparam int RW = WAYS * LW + WB;

  logic [1:0] replace_policy;
  logic       write_back_mode;
  logic       phase;
  logic       act_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [SETS-1:0] set_ok;
  logic [31:0] global_stamp;
  logic [RW-1:0] rdata, wdata;
  logic [SB-1:0] set_i;
  logic [TB-1:0] tag_i;
  logic [RW-1:0] row;
  logic hit_n, wb_n;
  logic [WB-1:0] way_n;
  logic [31:0] stamp_n;
  logic [13:0] victim_n;

  assign cfg_ready = !phase;
  assign busy = phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      replace_policy <= POL_LRU;
      write_back_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_POLICY) begin
        replace_policy <= cfg_data;
      end else if (cfg_index == REG_WB_MODE) begin
        write_back_mode <= cfg_data[0];
      end
    end
  end

  logic [SB-1:0] in_set;
  always_comb begin
    logic [ADDR_BITS-1:0] a;
    a = word_address[ADDR_BITS-1:0];
    if (SETS > 1) in_set = SB'(a >> OB);
    else in_set = '0;
  end

  always_comb begin
    if (SETS > 1) set_i = SB'(addr_r >> OB);
    else set_i = '0;
    tag_i = TB'(addr_r >> (OB + SBR));
  end

  sacc_ram #(.WIDTH(RW), .DEPTH(SETS > 1 ? SETS : 2)) u_set_ram (
    .clk(clk), .we(phase), .waddr(set_i), .wdata(wdata),
    .raddr(in_set), .rdata(rdata)
  );

  assign row = set_ok[set_i] ? rdata : '0;

  always_comb begin
    logic [WAYS-1:0] v, d, m;
    logic [TB-1:0] t [WAYS];
    logic [31:0] c [WAYS];
    logic [WB-1:0] fp, way, lw;
    logic [31:0] mn, nc, stamp;
    logic h, fnd, evict, wbr;
    logic [RW-1:0] nr;
    for (int w = 0; w < WAYS; w++) begin
      v[w] = row[w*LW];
      d[w] = row[w*LW+1];
      t[w] = row[w*LW+2 +: TB];
      c[w] = row[w*LW+2+TB +: 32];
      m[w] = v[w] && (t[w] == tag_i);
    end
    fp = row[WAYS*LW +: WB];
    h = 1'b0; fnd = 1'b0; way = '0; lw = '0; mn = c[0];
    for (int w = WAYS-1; w >= 0; w--) begin
      if (m[w]) begin h = 1'b1; way = WB'(w); end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (c[w] < mn) begin mn = c[w]; lw = WB'(w); end
    end
    evict = 1'b0; wbr = 1'b0;
    if (!h) begin
      for (int w = WAYS-1; w >= 0; w--) begin
        if (!v[w]) begin fnd = 1'b1; way = WB'(w); end
      end
      if (!fnd) begin
        evict = 1'b1;
        case (replace_policy)
          POL_LRU, POL_LFU: way = lw;
          POL_FIFO: way = (32'(fp) < WAYS) ? fp : '0;
          default: way = '0;
        endcase
        wbr = write_back_mode && d[way];
      end
    end
    nc = h ? c[way] : 32'd0;
    stamp = global_stamp;
    if (replace_policy == POL_LFU) begin
      nc = (nc == CNT_MAX) ? nc : nc + 32'd1;
    end else if (replace_policy == POL_LRU) begin
      stamp = (stamp == CNT_MAX) ? stamp : stamp + 32'd1;
      nc = stamp;
    end
    nr = row;
    nr[way*LW] = 1'b1;
    nr[way*LW+1] = act_r || (h && d[way]);
    nr[way*LW+2 +: TB] = tag_i;
    nr[way*LW+2+TB +: 32] = nc;
    if (evict) begin
      nr[WAYS*LW +: WB] = (32'(fp) + 1 >= WAYS) ? '0 : WB'(32'(fp) + 1);
    end
    wdata = nr;
    hit_n = h; way_n = way; wb_n = wbr; stamp_n = stamp;
    victim_n = wbr ? 14'((32'(t[way]) * SETS) + 32'(set_i)) : 14'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      done <= 1'b0;
      set_ok <= '0;
      global_stamp <= '0;
    end else begin
      done <= phase;
      if (start && !phase) begin
        phase <= 1'b1;
        act_r <= action;
        addr_r <= word_address[ADDR_BITS-1:0];
      end else if (phase) begin
        phase <= 1'b0;
        set_ok[set_i] <= 1'b1;
        global_stamp <= stamp_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (phase) begin
      hit <= hit_n;
      way_used <= 2'(way_n);
      set_number <= 4'(set_i);
      word_offset <= 2'(addr_r);
      fill_request <= !hit_n;
      writeback_request <= wb_n;
      victim_block <= victim_n;
      store_through <= act_r && !write_back_mode;
    end
  end
endmodule

// File: src/sacc_checker.sv
// ----------------------------------------------------------------------------
// Cache controller checker
// Port-level properties of the access handshake and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "set_assoc_cache_controller_assert.svh"
module sacc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic hit,
  input logic fill_request,
  input logic writeback_request,
  input logic [13:0] victim_block
);
  `SACC_NEXT(a_accept_busy, start && !busy, busy)
  `SACC_NEXT(a_busy_done, busy, done)
  `SACC_IMPLY(a_hit_fill, done, hit != fill_request)
  `SACC_IMPLY(a_wb_miss, done && writeback_request, fill_request)
  `SACC_IMPLY(a_victim_zero, done && !writeback_request, victim_block == 14'd0)
endmodule

bind set_assoc_cache_controller sacc_checker u_sacc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .hit(hit),
  .fill_request(fill_request), .writeback_request(writeback_request),
  .victim_block(victim_block)
);
